@@ rtl/cle_pkg.sv @@
//------------------------------------------------------------------------------
// cle_pkg
// Shared types, key codes and constants of the command line editor.
//------------------------------------------------------------------------------
package cle_pkg;

    localparam int LINE_WIDTH_DEF    = 64;
    localparam int HISTORY_LINES_DEF = 8;

    // key codes
    localparam logic [7:0] KEY_TOGGLE = 8'd96;
    localparam logic [7:0] KEY_ENTER  = 8'd13;
    localparam logic [7:0] KEY_BKSP   = 8'd8;
    localparam logic [7:0] KEY_DEL_A  = 8'd4;
    localparam logic [7:0] KEY_DEL_B  = 8'd138;
    localparam logic [7:0] KEY_UP_A   = 8'd16;
    localparam logic [7:0] KEY_UP_B   = 8'd136;
    localparam logic [7:0] KEY_UP_C   = 8'd137;
    localparam logic [7:0] KEY_DN_A   = 8'd14;
    localparam logic [7:0] KEY_DN_B   = 8'd130;
    localparam logic [7:0] KEY_DN_C   = 8'd131;
    localparam logic [7:0] KEY_RT_A   = 8'd6;
    localparam logic [7:0] KEY_RT_B   = 8'd134;
    localparam logic [7:0] KEY_LT_A   = 8'd2;
    localparam logic [7:0] KEY_LT_B   = 8'd132;
    localparam logic [7:0] KEY_HOME_A = 8'd1;
    localparam logic [7:0] KEY_HOME_B = 8'd135;
    localparam logic [7:0] KEY_END_A  = 8'd5;
    localparam logic [7:0] KEY_END_B  = 8'd129;
    localparam logic [7:0] KEY_PR_LO  = 8'd32;
    localparam logic [7:0] KEY_PR_HI  = 8'd126;

    // result types
    localparam logic [1:0] RT_STATUS = 2'd0;
    localparam logic [1:0] RT_CHAR   = 2'd1;
    localparam logic [1:0] RT_EMPTY  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_EMIT_RD,
        S_EMIT_OUT,
        S_SHL_RD,
        S_SHL_WR,
        S_SHR_RD,
        S_SHR_WR,
        S_CP_RD,
        S_CP_WR,
        S_STATUS
    } t_state;

endpackage

@@ rtl/command_line_editor_with_history_top.sv @@
//------------------------------------------------------------------------------
// command_line_editor_with_history_top
// Key-driven line editor over a ring of history lines held in one RAM.
//------------------------------------------------------------------------------
// Usage: one key code per input transaction (i_valid / o_stall). Each key
// gives one status transaction on the output channel (o_valid / i_stall),
// except an active enter, which gives one transaction per character of the
// line (or one empty marker); o_last_of_run marks the final one.
// Insert and delete walk the tail of the line through the character RAM,
// one character at a time; history recall copies up to LINE_WIDTH-1
// characters; enter reads each character and waits on the output
// handshake. The single RAM port sets this pace. One key is handled at a
// time; o_stall is high while a key is in work.
// Reset: lengths, cursor, ring position, history offset and active flag
// clear at once; character storage is not cleared. When the receiver
// stalls, the result is held in the output register until taken.
//------------------------------------------------------------------------------
module command_line_editor_with_history_top #(
    parameter int LINE_WIDTH    = cle_pkg::LINE_WIDTH_DEF,
    parameter int HISTORY_LINES = cle_pkg::HISTORY_LINES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_key_code,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [1:0] o_result_type,
    output logic [7:0] o_command_char,
    output logic [5:0] o_cursor_pos,
    output logic [5:0] o_line_length,
    output logic       o_editor_active,
    output logic       o_last_of_run
);
    localparam int LW    = (HISTORY_LINES > 2) ? $clog2(HISTORY_LINES) : 1;
    localparam int HW    = $clog2(HISTORY_LINES + 1);
    localparam int SW    = HW + 1;
    localparam int DEPTH = HISTORY_LINES * LINE_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [5:0] MAXC = 6'(LINE_WIDTH - 1);

    cle_pkg::t_state r_state, n_state;

    logic [5:0]    r_len [HISTORY_LINES];
    logic [LW-1:0] r_cl, n_cl;
    logic [HW-1:0] r_hoff, n_hoff;
    logic [5:0]    r_cur, n_cur;
    logic          r_act, n_act;
    logic [7:0]    r_key, n_key;
    logic [5:0]    r_idx, n_idx, r_end, n_end;
    logic [LW-1:0] r_src, n_src;
    logic [5:0]    r_elen, n_elen;

    logic          len_we;
    logic [LW-1:0] len_addr;
    logic [5:0]    len_val;

    logic          r_ov, n_ov;
    logic [1:0]    r_otype, n_otype;
    logic [7:0]    r_ochar, n_ochar;
    logic [5:0]    r_ocur, n_ocur, r_olen, n_olen;
    logic          r_oact, n_oact, r_olast, n_olast;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [7:0]    ram_wdata, ram_rdata;
    logic          out_free;

    cle_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] ln, input logic [5:0] col);
        addr_of = AW'(ln * LINE_WIDTH + col);
    endfunction

    // clamped view of the current line
    logic [5:0] len_c, cur_c;
    assign len_c = (r_len[r_cl] > MAXC) ? MAXC : r_len[r_cl];
    assign cur_c = (r_cur > len_c) ? len_c : r_cur;

    logic k_del, k_up, k_dn, k_rt, k_lt, k_home, k_end, k_pr;
    assign k_del  = (r_key == cle_pkg::KEY_DEL_A) || (r_key == cle_pkg::KEY_DEL_B);
    assign k_up   = (r_key == cle_pkg::KEY_UP_A) || (r_key == cle_pkg::KEY_UP_B) ||
                    (r_key == cle_pkg::KEY_UP_C);
    assign k_dn   = (r_key == cle_pkg::KEY_DN_A) || (r_key == cle_pkg::KEY_DN_B) ||
                    (r_key == cle_pkg::KEY_DN_C);
    assign k_rt   = (r_key == cle_pkg::KEY_RT_A) || (r_key == cle_pkg::KEY_RT_B);
    assign k_lt   = (r_key == cle_pkg::KEY_LT_A) || (r_key == cle_pkg::KEY_LT_B);
    assign k_home = (r_key == cle_pkg::KEY_HOME_A) || (r_key == cle_pkg::KEY_HOME_B);
    assign k_end  = (r_key == cle_pkg::KEY_END_A) || (r_key == cle_pkg::KEY_END_B);
    assign k_pr   = (r_key >= cle_pkg::KEY_PR_LO) && (r_key <= cle_pkg::KEY_PR_HI);

    // recall source line for a given new offset, ring wrap by compare and add
    function automatic logic [LW-1:0] src_of(input logic [LW-1:0] cl, input logic [HW-1:0] ho);
        logic [HW-1:0] m;
        logic [SW-1:0] s;
        m = (ho == HW'(HISTORY_LINES)) ? '0 : ho;
        if (SW'(cl) >= SW'(m)) begin
            s = SW'(cl) - SW'(m);
        end else begin
            s = SW'(cl) + SW'(HISTORY_LINES) - SW'(m);
        end
        src_of = LW'(s);
    endfunction

    logic [HW-1:0] hoff_up, hoff_dn, rc_hoff;
    logic [LW-1:0] src_up, src_dn, cl_next, rc_src;
    logic          rc_ok;
    logic [5:0]    rc_len;
    assign hoff_up = r_hoff + 1'b1;
    assign hoff_dn = r_hoff - 1'b1;
    assign src_up  = src_of(r_cl, hoff_up);
    assign src_dn  = src_of(r_cl, hoff_dn);
    assign cl_next = (r_cl == LW'(HISTORY_LINES - 1)) ? '0 : r_cl + 1'b1;

    // history recall view for up and down keys
    assign rc_ok   = k_up ? (r_hoff < HW'(HISTORY_LINES)) : (r_hoff != '0);
    assign rc_hoff = k_up ? hoff_up : hoff_dn;
    assign rc_src  = k_up ? src_up : src_dn;
    assign rc_len  = (rc_src == r_cl) ? len_c :
                     (r_len[rc_src] > MAXC) ? MAXC : r_len[rc_src];

    assign out_free = !r_ov || !i_stall;
    assign o_stall  = (r_state != cle_pkg::S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cle_pkg::S_IDLE:    if (i_valid) n_state = cle_pkg::S_DECODE;
            cle_pkg::S_DECODE:  n_state = cle_pkg::S_STATUS;
            cle_pkg::S_EMIT_RD: n_state = cle_pkg::S_EMIT_OUT;
            cle_pkg::S_EMIT_OUT: if (out_free) begin
                n_state = (r_idx + 6'd1 == r_elen) ? cle_pkg::S_IDLE : cle_pkg::S_EMIT_RD;
            end
            cle_pkg::S_SHL_RD:  n_state = cle_pkg::S_SHL_WR;
            cle_pkg::S_SHL_WR:  n_state = (r_idx + 6'd1 >= r_end) ? cle_pkg::S_STATUS
                                                                  : cle_pkg::S_SHL_RD;
            cle_pkg::S_SHR_RD:  n_state = cle_pkg::S_SHR_WR;
            cle_pkg::S_SHR_WR:  n_state = (r_idx == r_end) ? cle_pkg::S_STATUS
                                                           : cle_pkg::S_SHR_RD;
            cle_pkg::S_CP_RD:   n_state = cle_pkg::S_CP_WR;
            cle_pkg::S_CP_WR:   n_state = (r_idx + 6'd1 >= r_end) ? cle_pkg::S_STATUS
                                                                  : cle_pkg::S_CP_RD;
            cle_pkg::S_STATUS:  if (out_free) n_state = cle_pkg::S_IDLE;
            default:            n_state = cle_pkg::S_IDLE;
        endcase
        // decode picks the real branch
        if (r_state == cle_pkg::S_DECODE && r_key != cle_pkg::KEY_TOGGLE && r_act) begin
            priority if (r_key == cle_pkg::KEY_ENTER) begin
                n_state = (len_c == 6'd0) ? cle_pkg::S_STATUS : cle_pkg::S_EMIT_RD;
            end else if (r_key == cle_pkg::KEY_BKSP) begin
                if (cur_c != 6'd0 && cur_c < len_c) n_state = cle_pkg::S_SHL_RD;
            end else if (k_del) begin
                if (cur_c + 6'd1 < len_c) n_state = cle_pkg::S_SHL_RD;
            end else if (k_up || k_dn) begin
                if (rc_ok && rc_src != r_cl && rc_len != 6'd0) n_state = cle_pkg::S_CP_RD;
            end else if (k_pr && cur_c < MAXC) begin
                n_state = cle_pkg::S_SHR_RD;
            end else begin
                n_state = cle_pkg::S_STATUS;
            end
        end
    end

    // ram access
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = addr_of(r_cl, r_idx);
        ram_wdata = ram_rdata;
        unique case (r_state)
            cle_pkg::S_EMIT_RD:  ram_addr = addr_of(r_src, r_idx);
            cle_pkg::S_EMIT_OUT: ram_addr = addr_of(r_src, r_idx);
            cle_pkg::S_SHL_RD:   ram_addr = addr_of(r_cl, r_idx + 6'd1);
            cle_pkg::S_SHL_WR: begin
                ram_we = 1'b1;
            end
            cle_pkg::S_SHR_RD:   ram_addr = addr_of(r_cl, r_idx - 6'd1);
            cle_pkg::S_SHR_WR: begin
                ram_we = 1'b1;
                if (r_idx == r_end) ram_wdata = r_key;
            end
            cle_pkg::S_CP_RD:    ram_addr = addr_of(r_src, r_idx);
            cle_pkg::S_CP_WR:    ram_we = 1'b1;
            default: ;
        endcase
    end

    // key decode and edit state next values
    always_comb begin
        n_cl     = r_cl;
        n_hoff   = r_hoff;
        n_cur    = r_cur;
        n_act    = r_act;
        n_key    = r_key;
        n_idx    = r_idx;
        n_end    = r_end;
        n_src    = r_src;
        n_elen   = r_elen;
        len_we   = 1'b0;
        len_addr = r_cl;
        len_val  = len_c;
        unique case (r_state)
            cle_pkg::S_IDLE: if (i_valid) n_key = i_key_code;
            cle_pkg::S_DECODE: begin
                n_cur = cur_c;
                n_idx = '0;
                if (r_key == cle_pkg::KEY_TOGGLE) begin
                    n_act = !r_act;
                end else if (r_act) begin
                    len_we = 1'b1;
                    priority if (r_key == cle_pkg::KEY_ENTER) begin
                        n_src    = r_cl;
                        n_elen   = len_c;
                        n_cl     = cl_next;
                        len_addr = cl_next;
                        len_val  = '0;
                        n_cur    = '0;
                        n_hoff   = '0;
                    end else if (r_key == cle_pkg::KEY_BKSP) begin
                        if (cur_c != 6'd0) begin
                            n_idx   = cur_c - 6'd1;
                            n_end   = len_c - 6'd1;
                            len_val = len_c - 6'd1;
                            n_cur   = cur_c - 6'd1;
                        end
                    end else if (k_del) begin
                        if (cur_c < len_c) begin
                            n_idx   = cur_c;
                            n_end   = len_c - 6'd1;
                            len_val = len_c - 6'd1;
                        end
                    end else if (k_up || k_dn) begin
                        if (rc_ok) begin
                            n_hoff  = rc_hoff;
                            n_src   = rc_src;
                            n_end   = rc_len;
                            len_val = rc_len;
                            n_cur   = rc_len;
                        end else if (k_dn) begin
                            len_val = '0;
                            n_cur   = '0;
                        end
                    end else if (k_rt) begin
                        if (cur_c < len_c) n_cur = cur_c + 6'd1;
                    end else if (k_lt) begin
                        if (cur_c != 6'd0) n_cur = cur_c - 6'd1;
                    end else if (k_home) begin
                        n_cur = '0;
                    end else if (k_end) begin
                        n_cur = len_c;
                    end else if (k_pr && cur_c < MAXC) begin
                        // shift right from new last slot down to cursor
                        n_idx   = (len_c < MAXC) ? len_c : MAXC - 6'd1;
                        n_end   = cur_c;
                        len_val = (len_c < MAXC) ? len_c + 6'd1 : MAXC;
                        n_cur   = cur_c + 6'd1;
                    end else begin
                        // other keys leave the line as it is
                        len_val = len_c;
                    end
                end
            end
            cle_pkg::S_EMIT_OUT: if (out_free) n_idx = r_idx + 6'd1;
            cle_pkg::S_SHL_WR, cle_pkg::S_CP_WR: n_idx = r_idx + 6'd1;
            cle_pkg::S_SHR_WR: n_idx = r_idx - 6'd1;
            default: ;
        endcase
    end

    // output register next values
    always_comb begin
        n_ov    = r_ov && i_stall;
        n_otype = r_otype;
        n_ochar = r_ochar;
        n_ocur  = r_ocur;
        n_olen  = r_olen;
        n_oact  = r_oact;
        n_olast = r_olast;
        if (r_state == cle_pkg::S_EMIT_OUT && out_free) begin
            n_ov    = 1'b1;
            n_otype = cle_pkg::RT_CHAR;
            n_ochar = ram_rdata;
            n_ocur  = '0;
            n_olen  = '0;
            n_oact  = r_act;
            n_olast = (r_idx + 6'd1 == r_elen);
        end else if (r_state == cle_pkg::S_STATUS && out_free) begin
            n_ov    = 1'b1;
            n_ochar = '0;
            n_oact  = r_act;
            n_olast = 1'b1;
            if (r_key == cle_pkg::KEY_ENTER && r_act) begin
                n_otype = cle_pkg::RT_EMPTY;
                n_ocur  = '0;
                n_olen  = '0;
            end else begin
                n_otype = cle_pkg::RT_STATUS;
                n_ocur  = r_cur;
                n_olen  = r_len[r_cl];
            end
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cle_pkg::S_IDLE;
            r_cl    <= '0;
            r_hoff  <= '0;
            r_cur   <= '0;
            r_act   <= 1'b0;
            r_ov    <= 1'b0;
            for (int i = 0; i < HISTORY_LINES; i++) r_len[i] <= '0;
        end else begin
            r_state <= n_state;
            r_cl    <= n_cl;
            r_hoff  <= n_hoff;
            r_cur   <= n_cur;
            r_act   <= n_act;
            r_ov    <= n_ov;
            if (len_we) r_len[len_addr] <= len_val;
        end
    end

    // work and output registers
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_idx   <= n_idx;
        r_end   <= n_end;
        r_src   <= n_src;
        r_elen  <= n_elen;
        r_otype <= n_otype;
        r_ochar <= n_ochar;
        r_ocur  <= n_ocur;
        r_olen  <= n_olen;
        r_oact  <= n_oact;
        r_olast <= n_olast;
    end

    assign o_valid         = r_ov;
    assign o_result_type   = r_otype;
    assign o_command_char  = r_ochar;
    assign o_cursor_pos    = r_ocur;
    assign o_line_length   = r_olen;
    assign o_editor_active = r_oact;
    assign o_last_of_run   = r_olast;

`ifndef NO_ASSERTIONS
    // cursor never beyond the stored length while idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == cle_pkg::S_IDLE |-> r_cur <= r_len[r_cl])
        else $error("cursor beyond line length");
    // no key taken while a result is being built
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != cle_pkg::S_IDLE |-> o_stall)
        else $error("input open during work");
    // a held result stays put under stall
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && i_stall |=> r_ov && $stable(r_ochar) && $stable(r_otype))
        else $error("stalled result changed");
`endif
endmodule

@@ rtl/cle_ram.sv @@
//------------------------------------------------------------------------------
// cle_ram
// Generic single-port synchronous RAM with registered read.
//------------------------------------------------------------------------------
module cle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
